FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by deq_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Implication checked on every rising edge, off while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared widths, operation and status codes for the double-ended queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // Default number of store entries
    localparam int DEQ_DEPTH = 16;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Operation codes (other codes are no-ops)
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PUSH_FULL = 2'd2;

    // Control sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } deq_state_t;

endpackage

`default_nettype wire

FILE: rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a circular RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: s_tuser carries the operation (push front, push back,
//   pop front, pop back, clear; other codes do nothing), s_tdata the value to
//   push. One result per transfer leaves on m_*: front value, back value,
//   occupancy, empty flag and status (done, pop on empty, push on full).
//   Push, clear, no-op and a pop that empties the queue load the result into
//   the output register as the transfer is taken, and the next transfer can be
//   taken while it leaves, so one item per cycle while m_tready stays high.
//   A pop that leaves elements behind reads the new end element from the
//   element RAM's registered read port in ST_READ, taking no new transfer there.
//   Front and back values are cached in registers, so pushes never read.
//   Reset clears the pointers, the count and the output valid; the RAM is
//   not cleared, since only entries written by a push are ever read.
//   When the receiver stalls, the result holds in the output register and
//   s_tready stays low until it is taken or taken in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue import deq_pkg::*; #(
    parameter int  DEPTH = DEQ_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((2 * VALUE_W + CNT_W + 1 + STATUS_W + 7) / 8) * 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // slave side
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [VALUE_W-1:0] s_tdata,   // value
    input  wire logic [OP_W-1:0]    s_tuser,   // op
    // master side
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [OUT_W-1:0]   m_tdata    // front_value, back_value,
                                               // occupancy, is_empty, status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int OFS_BACK   = VALUE_W;
    localparam int OFS_OCC    = 2 * VALUE_W;
    localparam int OFS_EMPTY  = OFS_OCC + CNT_W;
    localparam int OFS_STATUS = OFS_EMPTY + 1;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    deq_state_t state_reg, state_next;

    logic [PTR_W-1:0]          front_pos_reg, front_pos_next;
    logic [PTR_W-1:0]          back_pos_reg, back_pos_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [VALUE_W-1:0] front_val_reg, front_val_next;
    logic signed [VALUE_W-1:0] back_val_reg, back_val_next;
    logic [STATUS_W-1:0]       pend_status_reg, pend_status_next;
    logic                      pend_front_reg, pend_front_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_front_reg, out_front_next;
    logic signed [VALUE_W-1:0] out_back_reg, out_back_next;
    logic [CNT_W-1:0]          out_count_reg, out_count_next;
    logic [STATUS_W-1:0]       out_status_reg, out_status_next;

    logic                      ram_we;
    logic [PTR_W-1:0]          ram_waddr;
    logic [VALUE_W-1:0]        ram_wdata;
    logic [PTR_W-1:0]          ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;

    logic                      accept;
    logic                      is_full;
    logic                      is_void;
    logic                      out_load;
    logic [STATUS_W-1:0]       load_status;
    logic signed [VALUE_W-1:0] in_value;

    // Element store
    deq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_deq_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Wrapping pointer steps
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        ptr_dec = (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CNT_FULL);
    assign is_void  = (count_reg == '0);
    assign in_value = $signed(s_tdata);

    // Control state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_pos_reg <= '0;
            back_pos_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_pos_reg <= front_pos_next;
            back_pos_reg  <= back_pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        front_val_reg   <= front_val_next;
        back_val_reg    <= back_val_next;
        pend_status_reg <= pend_status_next;
        pend_front_reg  <= pend_front_next;
        out_front_reg   <= out_front_next;
        out_back_reg    <= out_back_next;
        out_count_reg   <= out_count_next;
        out_status_reg  <= out_status_next;
    end

    // Next state, store access and result load
    always_comb
    begin
        state_next       = state_reg;
        front_pos_next   = front_pos_reg;
        back_pos_next    = back_pos_reg;
        count_next       = count_reg;
        front_val_next   = front_val_reg;
        back_val_next    = back_val_reg;
        pend_status_next = pend_status_reg;
        pend_front_next  = pend_front_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_front_next   = out_front_reg;
        out_back_next    = out_back_reg;
        out_count_next   = out_count_reg;
        out_status_next  = out_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = front_pos_reg;
        ram_wdata        = s_tdata;
        ram_raddr        = front_pos_reg;
        out_load         = 1'b0;
        load_status      = STATUS_DONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_load = 1'b1;
                    unique case (s_tuser)
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                load_status = STATUS_PUSH_FULL;
                            end
                            else
                            begin
                                front_pos_next = ptr_dec(front_pos_reg);
                                ram_we         = 1'b1;
                                ram_waddr      = front_pos_next;
                                front_val_next = in_value;
                                count_next     = count_reg + CNT_ONE;
                                if (is_void)
                                begin
                                    back_pos_next = front_pos_next;
                                    back_val_next = in_value;
                                end
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                load_status = STATUS_PUSH_FULL;
                            end
                            else
                            begin
                                back_pos_next = is_void ? front_pos_reg
                                                        : ptr_inc(back_pos_reg);
                                ram_we        = 1'b1;
                                ram_waddr     = back_pos_next;
                                back_val_next = in_value;
                                count_next    = count_reg + CNT_ONE;
                                if (is_void)
                                begin
                                    front_val_next = in_value;
                                end
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (is_void)
                            begin
                                load_status = STATUS_POP_EMPTY;
                            end
                            else
                            begin
                                front_pos_next = ptr_inc(front_pos_reg);
                                count_next     = count_reg - CNT_ONE;
                                // new front comes from the store
                                if (count_reg != CNT_ONE)
                                begin
                                    ram_raddr       = front_pos_next;
                                    pend_front_next = 1'b1;
                                    out_load        = 1'b0;
                                    state_next      = ST_READ;
                                end
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (is_void)
                            begin
                                load_status = STATUS_POP_EMPTY;
                            end
                            else
                            begin
                                back_pos_next = ptr_dec(back_pos_reg);
                                count_next    = count_reg - CNT_ONE;
                                // new back comes from the store
                                if (count_reg != CNT_ONE)
                                begin
                                    ram_raddr       = back_pos_next;
                                    pend_front_next = 1'b0;
                                    out_load        = 1'b0;
                                    state_next      = ST_READ;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            front_pos_next = '0;
                            count_next     = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    pend_status_next = load_status;
                end
            end
            ST_READ:
            begin
                if (pend_front_reg)
                begin
                    front_val_next = $signed(ram_rdata);
                end
                else
                begin
                    back_val_next = $signed(ram_rdata);
                end
                out_load    = 1'b1;
                load_status = pend_status_reg;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Result register load
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_front_next  = (count_next == '0) ? '0 : front_val_next;
            out_back_next   = (count_next == '0) ? '0 : back_val_next;
            out_count_next  = count_next;
            out_status_next = load_status;
        end
    end

    // Output packing, pad bits zero
    always_comb
    begin
        m_tdata                                 = '0;
        m_tdata[OFS_BACK-1:0]                   = out_front_reg;
        m_tdata[OFS_OCC-1:OFS_BACK]             = out_back_reg;
        m_tdata[OFS_EMPTY-1:OFS_OCC]            = out_count_reg;
        m_tdata[OFS_EMPTY]                      = (out_count_reg == '0);
        m_tdata[OFS_STATUS+STATUS_W-1:OFS_STATUS] = out_status_reg;
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level assertions for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module deq_checker import deq_pkg::*; #(
    parameter int  DEPTH = DEQ_DEPTH,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((2 * VALUE_W + CNT_W + 1 + STATUS_W + 7) / 8) * 8
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [OUT_W-1:0]   m_tdata
);

    localparam int OFS_OCC    = 2 * VALUE_W;
    localparam int OFS_EMPTY  = OFS_OCC + CNT_W;
    localparam int OFS_STATUS = OFS_EMPTY + 1;

    logic [VALUE_W-1:0]  chk_front;
    logic [VALUE_W-1:0]  chk_back;
    logic [CNT_W-1:0]    chk_count;
    logic                chk_empty;
    logic [STATUS_W-1:0] chk_status;
    logic                chk_in_xfer;

    // Result fields
    assign chk_front   = m_tdata[VALUE_W-1:0];
    assign chk_back    = m_tdata[OFS_OCC-1:VALUE_W];
    assign chk_count   = m_tdata[OFS_EMPTY-1:OFS_OCC];
    assign chk_empty   = m_tdata[OFS_EMPTY];
    assign chk_status  = m_tdata[OFS_STATUS+STATUS_W-1:OFS_STATUS];
    assign chk_in_xfer = s_tvalid && s_tready;

    // Empty flag agrees with occupancy
    `ASSERT_IMPL(a_empty_flag, clk, rst_n, m_tvalid, chk_empty == (chk_count == '0), "empty flag and occupancy disagree")

    // Empty queue reads zero at both ends
    `ASSERT_IMPL(a_empty_zero, clk, rst_n, m_tvalid && chk_empty, (chk_front == '0) && (chk_back == '0), "nonzero end value on empty queue")

    // A single element is both front and back
    `ASSERT_IMPL(a_single, clk, rst_n, m_tvalid && (chk_count == CNT_W'(1)), chk_front == chk_back, "front and back differ with one element")

    // Push dropped only when full, never beyond capacity
    `ASSERT_IMPL(a_full_drop, clk, rst_n, m_tvalid && (chk_status == STATUS_PUSH_FULL), chk_count == CNT_W'(DEPTH), "push dropped while not full")

    // A stalled result holds while no new transfer is taken
    `ASSERT_CLK(a_stall_hold, clk, rst_n, m_tvalid && !m_tready && !chk_in_xfer |=> m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind double_ended_queue deq_checker #(.DEPTH(DEPTH)) u_deq_checker (.*);

`default_nettype wire

FILE: tb/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the circular-buffer deque. Push, pop, clear and
// unused op codes are sent over the input stream. A shadow deque predicts the
// front, back, occupancy, empty flag and status of every result, and each
// result transfer is checked against the oldest prediction. Both stream sides
// idle at random, with one stretch where neither side idles.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;

    import deq_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    // Op codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

    // Result word, lowest field first in the low bits
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                is_empty;
        logic [4:0]          occupancy;
        logic [VALUE_W-1:0]  back_value;
        logic [VALUE_W-1:0]  front_value;
    } deque_result_t;

    localparam int RESULT_W = $bits(deque_result_t);

    // ------------------------------------------------------------------------
    // Shadow deque and result checker
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        logic [VALUE_W-1:0] slots[DEQ_DEPTH];
        int unsigned        head;
        int unsigned        count;
        deque_result_t      awaited[$];
        int                 mismatches;
        int                 checked;
        int                 pushes;
        int                 full_drops;
        int                 pops;
        int                 empty_pops;
        int                 clears;
        int                 unused_ops;

        function new();
            head  = 0;
            count = 0;
        endfunction

        function int unsigned tail_slot();
            return (head + count - 1) % DEQ_DEPTH;
        endfunction

        // Apply one accepted operation and queue the result it should give
        function void note_input(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val);
            deque_result_t res;
            res.status = STATUS_DONE;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    pushes++;
                    if (count == DEQ_DEPTH) begin
                        res.status = STATUS_PUSH_FULL;
                        full_drops++;
                    end else if (op == OP_PUSH_FRONT) begin
                        head = (head + DEQ_DEPTH - 1) % DEQ_DEPTH;
                        slots[head] = val;
                        count++;
                    end else begin
                        count++;
                        slots[tail_slot()] = val;
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    pops++;
                    if (count == 0) begin
                        res.status = STATUS_POP_EMPTY;
                        empty_pops++;
                    end else begin
                        if (op == OP_POP_FRONT)
                            head = (head + 1) % DEQ_DEPTH;
                        count--;
                    end
                end
                OP_CLEAR:
                begin
                    clears++;
                    head  = 0;
                    count = 0;
                end
                default:
                    unused_ops++;
            endcase
            res.occupancy = count[4:0];
            res.is_empty  = (count == 0);
            if (count == 0) begin
                res.front_value = '0;
                res.back_value  = '0;
            end else begin
                res.front_value = slots[head];
                res.back_value  = slots[tail_slot()];
            end
            awaited.push_back(res);
        endfunction

        function void report(string what, deque_result_t exp_r, deque_result_t got_r);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] %s: expected front %0d back %0d occ %0d empty %0d status %0d,",
                         $time, what,
                         $signed(exp_r.front_value), $signed(exp_r.back_value),
                         exp_r.occupancy, exp_r.is_empty, exp_r.status,
                         " got front %0d back %0d occ %0d empty %0d status %0d",
                         $signed(got_r.front_value), $signed(got_r.back_value),
                         got_r.occupancy, got_r.is_empty, got_r.status);
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(deque_result_t got_r);
            deque_result_t exp_r;
            if (awaited.size() == 0) begin
                report("result with nothing pending", '0, got_r);
                return;
            end
            exp_r = awaited.pop_front();
            checked++;
            if (got_r.front_value !== exp_r.front_value ||
                got_r.back_value  !== exp_r.back_value  ||
                got_r.occupancy   !== exp_r.occupancy   ||
                got_r.is_empty    !== exp_r.is_empty    ||
                got_r.status      !== exp_r.status)
                report("result mismatch", exp_r, got_r);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata  = '0;  // value
    logic [OP_W-1:0]     s_tuser  = '0;  // op
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [RESULT_W-1:0] m_tdata;        // front_value, back_value, occupancy,
                                         // is_empty, status

    bit              no_gaps = 1'b0;
    bit              rst_done = 1'b0;
    int              cycles = 0;
    deque_scoreboard deque_sb = new();

    double_ended_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Reset, held once at the start
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n    <= 1'b1;
        rst_done <= 1'b1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, deque_sb.awaited.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result side: check each transfer, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            deque_sb.check_result(deque_result_t'(m_tdata));
        m_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 35);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // One input transfer, with random idle cycles ahead of it
    task automatic send_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
        while (!no_gaps && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        deque_sb.note_input(op, val);
    endtask

    // Hold the input side until every pending result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (deque_sb.awaited.size() != 0) @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Push weight out of 95 sets whether the deque tends to fill or drain
    function automatic logic [OP_W-1:0] pick_op(int push_weight);
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return OP_CLEAR;
        if (r < 5)
            return OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        if (r < 5 + push_weight)
            return $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        return $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    initial
    begin
        int push_weight;
        int weights[3] = '{75, 48, 20};

        push_weight = weights[1];
        wait (rst_done);
        @(posedge clk);

        // Directed: empty pops, single-element pops, extremes, unused codes
        send_op(OP_POP_FRONT, VALUE_MAX);
        send_op(OP_POP_BACK, VALUE_MIN);
        send_op(OP_PUSH_FRONT, VALUE_MIN);
        send_op(OP_POP_BACK, '0);
        send_op(OP_PUSH_BACK, VALUE_MAX);
        send_op(OP_UNUSED_LO, '1);
        send_op(OP_UNUSED_MID, '1);
        send_op(OP_UNUSED_HI, '1);
        send_op(OP_POP_FRONT, '0);

        // Fill from both ends with wrap, then push on full and clear
        for (int i = 0; i < DEQ_DEPTH; i++) begin
            if (i % 2 == 0)
                send_op(OP_PUSH_FRONT, 32'hA5A5_0000 | i);
            else
                send_op(OP_PUSH_BACK, 32'h5A5A_0000 | i);
        end
        send_op(OP_PUSH_FRONT, '1);
        send_op(OP_PUSH_BACK, '0);
        send_op(OP_CLEAR, '0);

        drain_results();

        // Random phases that lean toward filling, balance or draining
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0)
                push_weight = weights[$urandom_range(2)];
            no_gaps = (n >= 600 && n < 900);
            if (n == 1200)
                drain_results();
            send_op(pick_op(push_weight), pick_value());
        end
        no_gaps = 1'b0;

        // Wait out the remaining results, then a few quiet cycles
        s_tvalid <= 1'b0;
        while (deque_sb.awaited.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d results: %0d pushes (%0d dropped on full), %0d pops",
                 deque_sb.checked, deque_sb.pushes, deque_sb.full_drops, deque_sb.pops);
        $display("  (%0d on empty), %0d clears, %0d unused op codes, %0d mismatches",
                 deque_sb.empty_pops, deque_sb.clears, deque_sb.unused_ops,
                 deque_sb.mismatches);
        if (deque_sb.mismatches == 0 && deque_sb.awaited.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
